[rtl/sfhlr_pkg.sv]
// Shared types and constants for the serial frame header/length receiver.
// Used by sfhlr_regs, sfhlr_parser and serial_frame_header_length_receiver.
// No dependencies.
package sfhlr_pkg;

    // Header depth default
    localparam int MAX_HEADER_DEFAULT = 4;

    // Header bytes carried by the header register
    localparam int HDR_REG_BYTES = 4;

    // Added to the length field to give the frame length
    localparam logic [8:0] LEN_OFFSET = 9'd5;

    // APB geometry
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    // Register indexes (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_HEADER_BYTES   = 3'd0,
        REG_HEADER_COUNT   = 3'd1,
        REG_DEFAULT_LENGTH = 3'd2,
        REG_LENGTH_MODE    = 3'd3,
        REG_LENGTH_POS     = 3'd4,
        REG_LENGTH_LIMIT   = 3'd5
    } reg_index_t;

    // Register reset values
    localparam logic [31:0] RST_HEADER_BYTES   = 32'd0;
    localparam logic [2:0]  RST_HEADER_COUNT   = 3'd0;
    localparam logic [7:0]  RST_DEFAULT_LENGTH = 8'd8;
    localparam logic        RST_LENGTH_MODE    = 1'b0;
    localparam logic [7:0]  RST_LENGTH_POS     = 8'd2;
    localparam logic [7:0]  RST_LENGTH_LIMIT   = 8'd250;

    // Per-byte outcome
    typedef enum logic [1:0] {
        EV_IGNORED = 2'd0,
        EV_STORED  = 2'd1,
        EV_RESYNC  = 2'd2,
        EV_RESTART = 2'd3
    } event_t;

    // Input item command
    typedef enum logic {
        CMD_BYTE  = 1'b0,
        CMD_CLEAR = 1'b1
    } command_t;

    // Configuration seen by the parser
    typedef struct packed {
        logic [31:0] header_bytes;
        logic [2:0]  header_count;
        logic [7:0]  default_length;
        logic        length_mode;
        logic [7:0]  length_position;
        logic [7:0]  length_limit;
    } cfg_t;

    // One result item
    typedef struct packed {
        logic       store_valid;
        logic [7:0] store_index;
        logic [7:0] store_byte;
        event_t     event_code;
        logic       frame_done;
        logic       frame_held;
    } result_t;

endpackage

[rtl/serial_frame_header_length_receiver.sv]
// Top level of the serial frame header/length receiver.
// Instantiates sfhlr_regs and sfhlr_parser; depends on sfhlr_pkg.
//
// Usage:
//   Input channel (s_valid/s_ready): one transfer per received byte
//   (s_command = 0) or per clear command (s_command = 1).
//   Result channel (m_valid/m_ready): exactly one transfer per input
//   transfer, in order, carrying store flag/index/byte, event code,
//   frame-done and frame-held flags.
//   APB port: six 32-bit registers at byte addresses 0x00..0x14.
//   Path: an accepted item is held in the input register, then
//   processed and captured in the result register, from which its
//   result is offered on the result channel.
//   Throughput: one item per cycle while the result channel does not
//   stall, set by the parser state update between the input and result registers.
//   Reset: aresetn (synchronous, active low) empties both registers,
//   loads register defaults and clears the frame state.
//   Stall: when m_ready is low the result register holds; one more item
//   is taken into the input register, then s_ready drops until the
//   result is taken.
module serial_frame_header_length_receiver #(
    parameter int MAX_HEADER = sfhlr_pkg::MAX_HEADER_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_command,
    input  logic [7:0]                        s_rx_byte,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_store_valid,
    output logic [7:0]                        m_store_index,
    output logic [7:0]                        m_store_byte,
    output logic [1:0]                        m_event_code,
    output logic                              m_frame_done,
    output logic                              m_frame_held,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sfhlr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [sfhlr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sfhlr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready
);
    import sfhlr_pkg::*;

    cfg_t       cfg;
    result_t    res_comb;
    result_t    res_reg;
    logic       in_valid_reg;
    logic       in_cmd_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic       advance;

    // Pipeline flow: move input stage forward when the result slot is free
    assign advance = in_valid_reg & (~out_valid_reg | m_ready);
    assign s_ready = ~in_valid_reg | advance;

    sfhlr_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfhlr_parser #(
        .MAX_HEADER (MAX_HEADER)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item_en (advance),
        .command (in_cmd_reg),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .result  (res_comb)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg  <= s_command;
            in_byte_reg <= s_rx_byte;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_comb;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_store_valid = res_reg.store_valid;
    assign m_store_index = res_reg.store_index;
    assign m_store_byte  = res_reg.store_byte;
    assign m_event_code  = res_reg.event_code;
    assign m_frame_done  = res_reg.frame_done;
    assign m_frame_held  = res_reg.frame_held;

endmodule

[rtl/sfhlr_regs.sv]
// APB configuration registers for the frame receiver.
// Depends on sfhlr_pkg for register indexes, reset values and cfg_t.
module sfhlr_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sfhlr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [sfhlr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sfhlr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready,
    output sfhlr_pkg::cfg_t                   cfg
);
    import sfhlr_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    reg_index_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_index_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    // Register writes; addresses past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_bytes    <= RST_HEADER_BYTES;
            cfg_reg.header_count    <= RST_HEADER_COUNT;
            cfg_reg.default_length  <= RST_DEFAULT_LENGTH;
            cfg_reg.length_mode     <= RST_LENGTH_MODE;
            cfg_reg.length_position <= RST_LENGTH_POS;
            cfg_reg.length_limit    <= RST_LENGTH_LIMIT;
        end else if (wr_en) begin
            case (idx)
                REG_HEADER_BYTES:   cfg_reg.header_bytes    <= pwdata[31:0];
                REG_HEADER_COUNT:   cfg_reg.header_count    <= pwdata[2:0];
                REG_DEFAULT_LENGTH: cfg_reg.default_length  <= pwdata[7:0];
                REG_LENGTH_MODE:    cfg_reg.length_mode     <= pwdata[0];
                REG_LENGTH_POS:     cfg_reg.length_position <= pwdata[7:0];
                REG_LENGTH_LIMIT:   cfg_reg.length_limit    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        prdata = '0;
        case (idx)
            REG_HEADER_BYTES:   prdata = cfg_reg.header_bytes;
            REG_HEADER_COUNT:   prdata = {29'd0, cfg_reg.header_count};
            REG_DEFAULT_LENGTH: prdata = {24'd0, cfg_reg.default_length};
            REG_LENGTH_MODE:    prdata = {31'd0, cfg_reg.length_mode};
            REG_LENGTH_POS:     prdata = {24'd0, cfg_reg.length_position};
            REG_LENGTH_LIMIT:   prdata = {24'd0, cfg_reg.length_limit};
            default:            prdata = '0;
        endcase
    end

endmodule

[rtl/sfhlr_parser.sv]
// Frame parser: header match, length field and completion tracking.
// Holds write position, expected length and the held-frame flag.
// Depends on sfhlr_pkg.
module sfhlr_parser #(
    parameter int MAX_HEADER = sfhlr_pkg::MAX_HEADER_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               item_en,
    input  logic               command,
    input  logic [7:0]         rx_byte,
    input  sfhlr_pkg::cfg_t    cfg,
    output sfhlr_pkg::result_t result
);
    import sfhlr_pkg::*;

    localparam logic [7:0] MaxHc = 8'(MAX_HEADER);

    logic [7:0] wpos_reg, wpos_next;
    logic [7:0] exp_len_reg, exp_len_next;
    logic       held_reg, held_next;

    logic [7:0] hc;
    logic [7:0] hdr_cur;
    logic [7:0] hdr0;
    logic [8:0] len_sum;
    logic [7:0] len_sat;
    logic       check;

    // Effective header count and the header byte at the current position
    assign hc = ({5'd0, cfg.header_count} > MaxHc) ? MaxHc : {5'd0, cfg.header_count};
    assign hdr_cur = (wpos_reg < 8'(HDR_REG_BYTES))
                   ? cfg.header_bytes[{wpos_reg[1:0], 3'b000} +: 8] : 8'd0;
    assign hdr0    = cfg.header_bytes[7:0];
    assign len_sum = {1'b0, rx_byte} + LEN_OFFSET;
    assign len_sat = len_sum[8] ? 8'hFF : len_sum[7:0];

    // Next state and result for the item at the input register
    always_comb begin
        wpos_next    = wpos_reg;
        exp_len_next = exp_len_reg;
        held_next    = held_reg;
        check        = 1'b1;
        result       = '0;
        result.event_code = EV_IGNORED;

        if (command == CMD_CLEAR) begin
            wpos_next    = '0;
            held_next    = 1'b0;
            exp_len_next = cfg.default_length;
            check        = 1'b0;
        end else if (held_reg) begin
            check = 1'b0;
        end else if (wpos_reg < hc) begin
            // header phase
            if (rx_byte == hdr_cur) begin
                result.store_valid = 1'b1;
                result.store_index = wpos_reg;
                result.store_byte  = rx_byte;
                result.event_code  = EV_STORED;
                wpos_next          = wpos_reg + 8'd1;
            end else if (rx_byte == hdr0) begin
                wpos_next         = 8'd1;
                result.event_code = EV_RESYNC;
            end else begin
                wpos_next         = '0;
                held_next         = 1'b0;
                exp_len_next      = cfg.default_length;
                result.event_code = EV_RESTART;
                check             = 1'b0;
            end
        end else if (wpos_reg < exp_len_reg) begin
            // payload phase, with optional length field
            if (cfg.length_mode && wpos_reg == cfg.length_position
                    && rx_byte > cfg.length_limit) begin
                if (rx_byte == hdr0) begin
                    wpos_next         = 8'd1;
                    result.event_code = EV_RESYNC;
                end else begin
                    wpos_next         = '0;
                    held_next         = 1'b0;
                    exp_len_next      = cfg.default_length;
                    result.event_code = EV_RESTART;
                    check             = 1'b0;
                end
            end else begin
                if (cfg.length_mode && wpos_reg == cfg.length_position) begin
                    exp_len_next = len_sat;
                end
                result.store_valid = 1'b1;
                result.store_index = wpos_reg;
                result.store_byte  = rx_byte;
                result.event_code  = EV_STORED;
                wpos_next          = wpos_reg + 8'd1;
            end
        end

        // completion check
        if (check && wpos_next >= exp_len_next) begin
            held_next         = 1'b1;
            wpos_next         = '0;
            result.frame_done = 1'b1;
        end
        result.frame_held = held_next;
    end

    // State update on each item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wpos_reg    <= '0;
            exp_len_reg <= RST_DEFAULT_LENGTH;
            held_reg    <= 1'b0;
        end else if (item_en) begin
            wpos_reg    <= wpos_next;
            exp_len_reg <= exp_len_next;
            held_reg    <= held_next;
        end
    end

endmodule

[tb/sv/sfhlr_result_checker.sv]
// Result checker for the serial frame header/length receiver testbench.
// Snoops the APB port and both streaming channels, predicts each result and compares.
// Depends on sfhlr_pkg for register indexes, event codes and the result layout.
module sfhlr_result_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input channel
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic                             s_command,
    input  logic [7:0]                       s_rx_byte,
    // result channel
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic                             m_store_valid,
    input  logic [7:0]                       m_store_index,
    input  logic [7:0]                       m_store_byte,
    input  logic [1:0]                       m_event_code,
    input  logic                             m_frame_done,
    input  logic                             m_frame_held,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sfhlr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sfhlr_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                             pready,
    // status for the testbench top
    output int unsigned                      mismatch_count,
    output int unsigned                      pending_results,
    output int unsigned                      results_checked,
    output int unsigned                      frames_completed
);

    timeunit 1ns;
    timeprecision 1ps;

    import sfhlr_pkg::*;

    // Shadow copy of the register file
    logic [31:0] cfg_hdr_bytes;
    logic [2:0]  cfg_hdr_count;
    logic [7:0]  cfg_def_len;
    logic        cfg_len_mode;
    logic [7:0]  cfg_len_pos;
    logic [7:0]  cfg_len_limit;

    // Frame assembly state
    logic [7:0]  wr_pos;
    logic [7:0]  frame_len;
    logic        held;

    // Results still owed by the block, oldest first
    result_t     owed_results[$];

    function automatic logic [7:0] header_byte(input int idx);
        if (idx >= HDR_REG_BYTES) return 8'h00;
        return cfg_hdr_bytes[8*idx +: 8];
    endfunction

    // Back to the start of a frame with the default length
    task automatic reload_frame();
        wr_pos    = 8'd0;
        held      = 1'b0;
        frame_len = cfg_def_len;
    endtask

    // Advance the frame state by one transfer and work out its result
    task automatic predict_frame_step(input logic cmd, input logic [7:0] rx,
                                      output result_t res);
        int         hdr_depth;
        logic       end_check;
        logic       keep;
        logic [8:0] len_sum;
        res            = '0;
        res.event_code = EV_IGNORED;
        hdr_depth      = (cfg_hdr_count > MAX_HEADER_DEFAULT) ? MAX_HEADER_DEFAULT
                                                               : int'(cfg_hdr_count);
        end_check      = 1'b1;
        if (cmd == CMD_CLEAR) begin
            reload_frame();
            end_check = 1'b0;
        end else if (held) begin
            end_check = 1'b0;
        end else if (wr_pos < hdr_depth) begin
            // header match, resync on header byte 0, or restart
            if (rx == header_byte(wr_pos)) begin
                res.store_valid = 1'b1;
                res.store_index = wr_pos;
                res.store_byte  = rx;
                res.event_code  = EV_STORED;
                wr_pos          = wr_pos + 8'd1;
            end else if (rx == header_byte(0)) begin
                wr_pos         = 8'd1;
                res.event_code = EV_RESYNC;
            end else begin
                reload_frame();
                res.event_code = EV_RESTART;
                end_check      = 1'b0;
            end
        end else if (wr_pos < frame_len) begin
            keep = 1'b1;
            // length field: over limit drops the byte, else sets the frame length
            if (cfg_len_mode && wr_pos == cfg_len_pos) begin
                if (rx > cfg_len_limit) begin
                    keep = 1'b0;
                    if (rx == header_byte(0)) begin
                        wr_pos         = 8'd1;
                        res.event_code = EV_RESYNC;
                    end else begin
                        reload_frame();
                        res.event_code = EV_RESTART;
                        end_check      = 1'b0;
                    end
                end else begin
                    len_sum   = {1'b0, rx} + LEN_OFFSET;
                    frame_len = (len_sum > 9'd255) ? 8'hFF : len_sum[7:0];
                end
            end
            if (keep) begin
                res.store_valid = 1'b1;
                res.store_index = wr_pos;
                res.store_byte  = rx;
                res.event_code  = EV_STORED;
                wr_pos          = wr_pos + 8'd1;
            end
        end
        // completion check
        if (end_check && wr_pos >= frame_len) begin
            held           = 1'b1;
            wr_pos         = 8'd0;
            res.frame_done = 1'b1;
        end
        res.frame_held = held;
    endtask

    always @(posedge aclk) begin : frame_check
        result_t predicted;
        result_t seen;
        result_t want;
        if (!aresetn) begin
            cfg_hdr_bytes    = RST_HEADER_BYTES;
            cfg_hdr_count    = RST_HEADER_COUNT;
            cfg_def_len      = RST_DEFAULT_LENGTH;
            cfg_len_mode     = RST_LENGTH_MODE;
            cfg_len_pos      = RST_LENGTH_POS;
            cfg_len_limit    = RST_LENGTH_LIMIT;
            wr_pos           = 8'd0;
            frame_len        = RST_DEFAULT_LENGTH;
            held             = 1'b0;
            owed_results.delete();
            mismatch_count   = 0;
            pending_results  = 0;
            results_checked  = 0;
            frames_completed = 0;
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (reg_index_t'(paddr[APB_ADDR_W-1:2]))
                    REG_HEADER_BYTES:   cfg_hdr_bytes = pwdata[31:0];
                    REG_HEADER_COUNT:   cfg_hdr_count = pwdata[2:0];
                    REG_DEFAULT_LENGTH: cfg_def_len   = pwdata[7:0];
                    REG_LENGTH_MODE:    cfg_len_mode  = pwdata[0];
                    REG_LENGTH_POS:     cfg_len_pos   = pwdata[7:0];
                    REG_LENGTH_LIMIT:   cfg_len_limit = pwdata[7:0];
                    default: ;
                endcase
            end
            // input transfer: predict and queue
            if (s_valid && s_ready) begin
                predict_frame_step(s_command, s_rx_byte, predicted);
                owed_results.push_back(predicted);
            end
            // result transfer: compare with the oldest prediction
            if (m_valid && m_ready) begin
                seen.store_valid = m_store_valid;
                seen.store_index = m_store_index;
                seen.store_byte  = m_store_byte;
                seen.event_code  = event_t'(m_event_code);
                seen.frame_done  = m_frame_done;
                seen.frame_held  = m_frame_held;
                results_checked++;
                if (m_frame_done === 1'b1) frames_completed++;
                if (owed_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result transfer with nothing pending: %h", $realtime,
                                 seen);
                end else begin
                    want = owed_results.pop_front();
                    if (seen !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"%0t: result %0d mismatch: exp sv=%0b idx=%0d ",
                                      "byte=%h ev=%0d done=%0b held=%0b, got sv=%0b ",
                                      "idx=%0d byte=%h ev=%0d done=%0b held=%0b"},
                                     $realtime, results_checked,
                                     want.store_valid, want.store_index, want.store_byte,
                                     want.event_code, want.frame_done, want.frame_held,
                                     seen.store_valid, seen.store_index, seen.store_byte,
                                     seen.event_code, seen.frame_done, seen.frame_held);
                    end
                end
            end
            pending_results = owed_results.size();
        end
    end

endmodule

[tb/sv/serial_frame_header_length_receiver_tb.sv]
// Testbench top for the serial frame header/length receiver: clock, reset,
// stimulus, receiver stalls and the final verdict.
// Depends on sfhlr_pkg, the receiver RTL and sfhlr_result_checker.
module serial_frame_header_length_receiver_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sfhlr_pkg::*;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic                  s_command     = CMD_BYTE;
    logic [7:0]            s_rx_byte     = 8'h00;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic                  m_store_valid;
    logic [7:0]            m_store_index;
    logic [7:0]            m_store_byte;
    logic [1:0]            m_event_code;
    logic                  m_frame_done;
    logic                  m_frame_held;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int unsigned mismatch_count;
    int unsigned pending_results;
    int unsigned results_checked;
    int unsigned frames_completed;

    // Register values currently programmed, used to shape frames
    logic [31:0] stim_hdr_bytes = RST_HEADER_BYTES;
    logic [2:0]  stim_hdr_count = RST_HEADER_COUNT;
    logic [7:0]  stim_def_len   = RST_DEFAULT_LENGTH;
    logic        stim_len_mode  = RST_LENGTH_MODE;
    logic [7:0]  stim_len_pos   = RST_LENGTH_POS;
    logic [7:0]  stim_len_limit = RST_LENGTH_LIMIT;

    int items_sent       = 0;
    int clears_sent      = 0;
    int settings_applied = 1;
    int burst_left       = 0;
    int stall_mode       = 0;
    int stall_timer      = 0;

    serial_frame_header_length_receiver i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_store_valid (m_store_valid),
        .m_store_index (m_store_index),
        .m_store_byte  (m_store_byte),
        .m_event_code  (m_event_code),
        .m_frame_done  (m_frame_done),
        .m_frame_held  (m_frame_held),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    sfhlr_result_checker i_result_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_store_valid    (m_store_valid),
        .m_store_index    (m_store_index),
        .m_store_byte     (m_store_byte),
        .m_event_code     (m_event_code),
        .m_frame_done     (m_frame_done),
        .m_frame_held     (m_frame_held),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .pready           (pready),
        .mismatch_count   (mismatch_count),
        .pending_results  (pending_results),
        .results_checked  (results_checked),
        .frames_completed (frames_completed)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Receiver stalls: switch between always ready, random, mostly stalled, mostly ready
    always @(posedge aclk) begin
        if (stall_timer == 0) begin
            stall_mode  <= $urandom_range(0, 3);
            stall_timer <= $urandom_range(50, 300);
        end else begin
            stall_timer <= stall_timer - 1;
        end
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            2:       m_ready <= ($urandom_range(0, 4) == 0);
            default: m_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Run limit
    initial begin
        #10ms;
        $display("serial_frame_header_length_receiver test failed");
        $finish;
    end

    // One input transfer; the sender runs in bursts with random gaps between them
    task automatic push_item(input command_t cmd, input logic [7:0] rx);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_rx_byte <= rx;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        items_sent++;
        if (cmd == CMD_CLEAR) clears_sent++;
    endtask

    // Stop sending and let every owed result come out
    task automatic wait_drained();
        s_valid    <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        wait (pending_results == 0);
        repeat (4) @(posedge aclk);
    endtask

    // Setup and access phase; the caller releases psel after the last write
    task automatic apb_write(input reg_index_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
    endtask

    // Program all registers while the block is idle
    task automatic apply_settings(input logic [31:0] hdr, input logic [2:0] cnt,
                                  input logic [7:0] def_len, input logic mode,
                                  input logic [7:0] pos, input logic [7:0] lim);
        wait_drained();
        apb_write(REG_HEADER_BYTES, hdr);
        apb_write(REG_HEADER_COUNT, {29'd0, cnt});
        apb_write(REG_DEFAULT_LENGTH, {24'd0, def_len});
        apb_write(REG_LENGTH_MODE, {31'd0, mode});
        apb_write(REG_LENGTH_POS, {24'd0, pos});
        apb_write(REG_LENGTH_LIMIT, {24'd0, lim});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        stim_hdr_bytes = hdr;
        stim_hdr_count = cnt;
        stim_def_len   = def_len;
        stim_len_mode  = mode;
        stim_len_pos   = pos;
        stim_len_limit = lim;
        settings_applied++;
    endtask

    // Well-formed frame for the current settings, optionally broken at one byte,
    // then up to two extra bytes and a clear
    task automatic send_frame(input bit corrupt);
        int         hdr_depth;
        int         total;
        int         pos;
        int         bad_at;
        bit         broken;
        bit         at_len_field;
        logic [7:0] b;
        hdr_depth = (stim_hdr_count > 4) ? 4 : int'(stim_hdr_count);
        total     = stim_def_len;
        bad_at    = $urandom_range(0, hdr_depth + 3);
        broken    = 1'b0;
        pos       = 0;
        while (pos < total && !broken) begin
            at_len_field = stim_len_mode && pos == stim_len_pos && pos >= hdr_depth;
            if (pos < hdr_depth) begin
                b = stim_hdr_bytes[8*pos +: 8];
            end else if (at_len_field) begin
                case ($urandom_range(0, 9))
                    0: b = stim_len_limit;
                    1: b = (stim_len_limit == 8'hFF) ? 8'hFF
                           : 8'($urandom_range(int'(stim_len_limit) + 1, 255));
                    2: b = stim_hdr_bytes[7:0];
                    3: b = 8'($urandom_range(0, stim_len_limit));
                    default: b = 8'($urandom_range(0, (stim_len_limit < 12) ?
                                                      stim_len_limit : 12));
                endcase
            end else begin
                b = 8'($urandom);
            end
            if (corrupt && pos == bad_at) begin
                b      = $urandom_range(0, 1) ? stim_hdr_bytes[7:0] : 8'($urandom);
                broken = 1'b1;
            end
            push_item(CMD_BYTE, b);
            if (at_len_field) begin
                if (b > stim_len_limit) broken = 1'b1;
                else total = (int'(b) + 5 > 255) ? 255 : int'(b) + 5;
            end
            pos++;
        end
        repeat ($urandom_range(0, 2)) push_item(CMD_BYTE, 8'($urandom));
        push_item(CMD_CLEAR, 8'($urandom));
    endtask

    // Mixed traffic: mostly frames, some noise, clears and pauses
    task automatic run_traffic(input int n_items);
        int stop_at;
        int pick;
        stop_at = items_sent + n_items;
        push_item(CMD_CLEAR, 8'($urandom));
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_frame($urandom_range(0, 4) == 0);
            end else if (pick < 84) begin
                repeat ($urandom_range(1, 4)) push_item(CMD_BYTE, 8'($urandom));
                if ($urandom_range(0, 1)) push_item(CMD_CLEAR, 8'($urandom));
            end else if (pick < 91) begin
                push_item(CMD_CLEAR, 8'($urandom));
            end else if (pick < 95) begin
                wait_drained();
            end else begin
                // runs of header byte 0 exercise resync
                repeat ($urandom_range(1, 3)) push_item(CMD_BYTE, stim_hdr_bytes[7:0]);
            end
        end
    endtask

    initial begin
        logic [2:0] cnt;
        logic [7:0] def_len;
        logic [7:0] pos;
        logic [7:0] lim;
        int         pick;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: no header, fixed length 8, then a held byte and a clear
        push_item(CMD_BYTE, 8'h00);
        push_item(CMD_BYTE, 8'hFF);
        push_item(CMD_BYTE, 8'h01);
        push_item(CMD_BYTE, 8'h80);
        push_item(CMD_BYTE, 8'h7F);
        push_item(CMD_BYTE, 8'hFE);
        push_item(CMD_BYTE, 8'h55);
        push_item(CMD_BYTE, 8'hAA);
        push_item(CMD_BYTE, 8'h33);
        push_item(CMD_CLEAR, 8'hFF);

        // Three header bytes, length field at 3: restart, resync, over-limit, good frame
        apply_settings(32'h3CC35AA5, 3'd3, 8'd20, 1'b1, 8'd3, 8'd250);
        push_item(CMD_CLEAR, 8'h00);
        push_item(CMD_BYTE, 8'hA5);
        push_item(CMD_BYTE, 8'h00);
        push_item(CMD_BYTE, 8'hA5);
        push_item(CMD_BYTE, 8'hA5);
        push_item(CMD_BYTE, 8'h5A);
        push_item(CMD_BYTE, 8'hC3);
        push_item(CMD_BYTE, 8'hFB);
        push_item(CMD_BYTE, 8'hA5);
        push_item(CMD_BYTE, 8'h5A);
        push_item(CMD_BYTE, 8'hC3);
        push_item(CMD_BYTE, 8'h00);
        push_item(CMD_BYTE, 8'h11);
        push_item(CMD_CLEAR, 8'h5A);

        // Extreme settings with random content
        apply_settings(32'hFFFFFFFF, 3'd7, 8'd255, 1'b1, 8'd4, 8'd0);
        run_traffic(60);
        apply_settings(32'h00000000, 3'd0, 8'd0, 1'b0, 8'd254, 8'd250);
        run_traffic(30);
        apply_settings(32'h807F01FE, 3'd1, 8'd1, 1'b1, 8'd0, 8'd255);
        run_traffic(40);
        apply_settings($urandom, 3'd2, 8'd8, 1'b1, 8'd2, 8'd255);
        run_traffic(60);
        apply_settings(32'hC33C00FF, 3'd4, 8'd255, 1'b0, 8'd254, 8'd250);
        run_traffic(20);

        // Random settings, mostly short frames
        while (items_sent < 1250) begin
            cnt     = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4))
                                                 : 3'($urandom_range(5, 7));
            pick    = $urandom_range(0, 19);
            def_len = (pick < 16) ? 8'($urandom_range(1, 24)) :
                      (pick < 18) ? 8'd255 :
                      (pick < 19) ? 8'd0 : 8'($urandom_range(1, 255));
            pick    = $urandom_range(0, 9);
            pos     = (pick < 8) ? 8'($urandom_range(0, 8)) :
                      (pick < 9) ? 8'd254 : 8'($urandom_range(0, 254));
            pick    = $urandom_range(0, 9);
            lim     = (pick < 7) ? 8'($urandom_range(0, 250)) :
                      (pick < 8) ? 8'd0 :
                      (pick < 9) ? 8'd250 : 8'd255;
            apply_settings($urandom, cnt, def_len, 1'($urandom_range(0, 1)), pos, lim);
            run_traffic($urandom_range(60, 160));
        end

        wait_drained();
        repeat (6) @(posedge aclk);

        $display("Covered %0d input transfers (%0d clears) under %0d register settings.",
                 items_sent, clears_sent, settings_applied);
        $display("Compared %0d results, %0d of them completing a frame.",
                 results_checked, frames_completed);
        if (mismatch_count == 0) begin
            $display("serial_frame_header_length_receiver test passed");
        end else begin
            $display("serial_frame_header_length_receiver test failed");
        end
        $finish;
    end

endmodule
